### rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WS_W = 7;

    typedef struct packed {
        logic valid;
        logic gt;
        logic rm;
    } cell_stat_t;

    typedef struct packed {
        cell_stat_t stat;
        logic       after_rm;
    } cell_flags_t;

endpackage

`default_nettype wire

### rtl/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module swm_cell #(
    parameter int IDX         = 0,
    parameter int SAMPLE_BITS = 16,
    parameter int AGE_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire                          clk,
    input  wire                          en,
    input  wire signed [SAMPLE_BITS-1:0] sample,
    input  wire        [CNT_W-1:0]       fill_cur,
    input  wire        [CNT_W-1:0]       oldest_age,
    input  wire                          full,
    input  wire swm_pkg::cell_flags_t    own_flags,
    input  wire swm_pkg::cell_flags_t    left_flags,
    input  wire swm_pkg::cell_flags_t    right_flags,
    input  wire signed [SAMPLE_BITS-1:0] left_val,
    input  wire        [AGE_W-1:0]       left_age,
    input  wire signed [SAMPLE_BITS-1:0] right_val,
    input  wire        [AGE_W-1:0]       right_age,
    output logic signed [SAMPLE_BITS-1:0] val,
    output logic       [AGE_W-1:0]       age,
    output swm_pkg::cell_stat_t          stat
);

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic        [AGE_W-1:0]       age_reg;
    logic        [AGE_W-1:0]       age_next;
    logic                          keep_own;
    logic                          take_right;
    logic                          take_left;

    always_comb
    begin
        stat.valid = (CNT_W'(IDX) < fill_cur);
        stat.gt    = stat.valid && (val_reg > sample);
        stat.rm    = full && stat.valid && (CNT_W'(age_reg) == oldest_age);
    end

    // Removal shifts entries down, insertion shifts them up; the two cancel.
    assign keep_own   = own_flags.stat.valid && !own_flags.stat.rm &&
                        (own_flags.stat.gt == own_flags.after_rm);
    assign take_right = right_flags.stat.valid && !right_flags.stat.rm &&
                        !right_flags.stat.gt && right_flags.after_rm;
    assign take_left  = left_flags.stat.valid && !left_flags.stat.rm &&
                        left_flags.stat.gt && !left_flags.after_rm;

    always_comb
    begin
        if (keep_own)
        begin
            val_next = val_reg;
            age_next = age_reg + AGE_W'(1);
        end
        else if (take_right)
        begin
            val_next = right_val;
            age_next = right_age + AGE_W'(1);
        end
        else if (take_left)
        begin
            val_next = left_val;
            age_next = left_age + AGE_W'(1);
        end
        else
        begin
            val_next = sample;
            age_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            val_reg <= val_next;
            age_reg <= age_next;
        end
    end

    assign val = val_reg;
    assign age = age_reg;

endmodule

`default_nettype wire

### rtl/sliding_window_median.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake               Contents
// s_axis    in   s_axis_tvalid/tready    tdata: sample; tuser: start_req
// m_axis    out  m_axis_tvalid/tready    tdata: median_x2
// cfg       in   cfg_we                  cfg_wdata: window_size
//
// One sample per cycle while the input is not stalled: a row of sorted cells
// drops the oldest entry and inserts the new sample in the same update;
// the median is registered into the output register once the output is free.
// Reset: window size 3, window empty. Cell contents are not reset.
// Input stalls only while a result is waiting and the output is stalled.

module sliding_window_median #(
    parameter int MAX_WINDOW  = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire  [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,  // sample
    input  wire                        s_axis_tuser,  // start_req
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [((SAMPLE_BITS + 8) / 8) * 8 - 1:0] m_axis_tdata,  // median_x2
    input  wire                        cfg_we,
    input  wire  [swm_pkg::WS_W-1:0]   cfg_wdata
);

    localparam int OUT_W       = SAMPLE_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int CNT_W       = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [swm_pkg::WS_W-1:0]      ws_reg;
    logic [CNT_W-1:0]              fill_reg;
    logic [CNT_W-1:0]              fill_next;
    logic                          pend_reg;
    logic                          m_valid_reg;
    logic [OUT_W-1:0]              out_data_reg;

    logic [CNT_W-1:0]              w_eff;
    logic [CNT_W-1:0]              oldest_age;
    logic [CNT_W-1:0]              hi_idx;
    logic [CNT_W-1:0]              lo_idx;
    logic [CNT_W-1:0]              fill_cur;
    logic                          full_cur;
    logic                          produce;
    logic                          accept;
    logic                          out_free;
    logic                          load;
    logic signed [SAMPLE_BITS-1:0] sample;

    logic signed [SAMPLE_BITS-1:0] cell_val  [MAX_WINDOW];
    logic        [AGE_W-1:0]       cell_age  [MAX_WINDOW];
    swm_pkg::cell_stat_t           cell_stat [MAX_WINDOW];
    swm_pkg::cell_flags_t          cell_flags[MAX_WINDOW];
    logic        [MAX_WINDOW-1:0]  rm_vec;
    logic        [MAX_WINDOW-1:0]  after_rm;

    logic signed [SAMPLE_BITS-1:0] lo_val;
    logic signed [SAMPLE_BITS-1:0] hi_val;
    logic signed [OUT_W-1:0]       median_sum;

    always_comb
    begin
        if (ws_reg == '0)
            w_eff = CNT_W'(1);
        else if (int'(ws_reg) > MAX_WINDOW)
            w_eff = CNT_W'(MAX_WINDOW);
        else
            w_eff = CNT_W'(ws_reg);
        oldest_age = w_eff - CNT_W'(1);
        hi_idx     = w_eff >> 1;
        lo_idx     = w_eff[0] ? hi_idx : hi_idx - CNT_W'(1);
    end

    assign sample   = s_axis_tdata[SAMPLE_BITS-1:0];
    assign out_free = !m_valid_reg || m_axis_tready;
    assign load     = pend_reg && out_free;
    assign s_axis_tready = !pend_reg || out_free;
    assign accept   = s_axis_tvalid && s_axis_tready;

    assign fill_cur  = s_axis_tuser ? '0 : fill_reg;
    assign full_cur  = (fill_cur == w_eff);
    assign produce   = full_cur || ((fill_cur + CNT_W'(1)) == w_eff);
    assign fill_next = full_cur ? fill_cur : fill_cur + CNT_W'(1);

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
            rm_vec[i] = cell_stat[i].rm;
    end

    always_comb
    begin
        logic acc;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            acc = 1'b0;
            for (int j = 0; j < MAX_WINDOW; j++)
            begin
                if (j < i)
                    acc = acc | rm_vec[j];
            end
            after_rm[i] = acc;
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            cell_flags[i].stat     = cell_stat[i];
            cell_flags[i].after_rm = after_rm[i];
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_WINDOW; g++)
        begin : g_cell
            swm_pkg::cell_flags_t          left_flags;
            swm_pkg::cell_flags_t          right_flags;
            logic signed [SAMPLE_BITS-1:0] left_val;
            logic signed [SAMPLE_BITS-1:0] right_val;
            logic        [AGE_W-1:0]       left_age;
            logic        [AGE_W-1:0]       right_age;

            if (g == 0)
            begin : g_first
                assign left_flags = '0;
                assign left_val   = '0;
                assign left_age   = '0;
            end
            else
            begin : g_mid_l
                assign left_flags = cell_flags[g-1];
                assign left_val   = cell_val[g-1];
                assign left_age   = cell_age[g-1];
            end

            if (g == MAX_WINDOW - 1)
            begin : g_last
                assign right_flags = '0;
                assign right_val   = '0;
                assign right_age   = '0;
            end
            else
            begin : g_mid_r
                assign right_flags = cell_flags[g+1];
                assign right_val   = cell_val[g+1];
                assign right_age   = cell_age[g+1];
            end

            swm_cell #(
                .IDX         (g),
                .SAMPLE_BITS (SAMPLE_BITS),
                .AGE_W       (AGE_W),
                .CNT_W       (CNT_W)
            ) u_cell (
                .clk         (clk),
                .en          (accept),
                .sample      (sample),
                .fill_cur    (fill_cur),
                .oldest_age  (oldest_age),
                .full        (full_cur),
                .own_flags   (cell_flags[g]),
                .left_flags  (left_flags),
                .right_flags (right_flags),
                .left_val    (left_val),
                .left_age    (left_age),
                .right_val   (right_val),
                .right_age   (right_age),
                .val         (cell_val[g]),
                .age         (cell_age[g]),
                .stat        (cell_stat[g])
            );
        end
    endgenerate

    always_comb
    begin
        lo_val = '0;
        hi_val = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
        begin
            if (CNT_W'(i) == lo_idx)
                lo_val = lo_val | cell_val[i];
            if (CNT_W'(i) == hi_idx)
                hi_val = hi_val | cell_val[i];
        end
        median_sum = OUT_W'(lo_val) + OUT_W'(hi_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= swm_pkg::WS_W'(3);
            fill_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                ws_reg   <= cfg_wdata;
                fill_reg <= '0;
            end
            else if (accept)
            begin
                fill_reg <= fill_next;
            end

            if (accept)
                pend_reg <= produce;
            else if (load)
                pend_reg <= 1'b0;

            if (load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_data_reg <= median_sum;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'(out_data_reg);

endmodule

`default_nettype wire

### tb/sv/tb_sliding_window_median.sv
`timescale 1ns / 1ps

module tb_sliding_window_median;

    localparam int MAX_W      = 64;
    localparam int SMP_W      = 16;
    localparam int MED_W      = SMP_W + 1;
    localparam int ITEM_GOAL  = 1650;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_PAD  = 6;
    localparam int MAX_PRINTS = 40;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    wire                        s_axis_tready;
    logic [15:0]                s_axis_tdata = '0;   // [15:0] sample
    logic                       s_axis_tuser = 1'b0; // [0] start_req
    wire                        m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    wire  [23:0]                m_axis_tdata;        // [16:0] median_x2
    logic                       cfg_we = 1'b0;
    logic [swm_pkg::WS_W-1:0]   cfg_wdata = '0;

    sliding_window_median #(
        .MAX_WINDOW  (MAX_W),
        .SAMPLE_BITS (SMP_W)
    ) uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // window model
    logic signed [SMP_W-1:0]    arrival_ring [MAX_W];
    logic signed [SMP_W-1:0]    sorted_vals [MAX_W];
    logic [swm_pkg::WS_W-1:0]   window_code = 7'd3;
    int                         fill_n = 0;
    int                         ring_ptr = 0;
    logic signed [MED_W-1:0]    expected_medians [$];

    int                         mismatches = 0;
    int                         n_samples = 0;
    int                         n_medians = 0;
    int                         n_configs = 0;
    int                         idle_cycles = 0;
    int                         burst_left = 0;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTS)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    function automatic int window_len();
        if (window_code == 0)
            return 1;
        if (window_code > MAX_W)
            return MAX_W;
        return int'(window_code);
    endfunction

    task automatic sorted_insert(input logic signed [SMP_W-1:0] v, input int n);
        int i;
        i = 0;
        while (i < n && sorted_vals[i] <= v)
            i++;
        for (int j = n; j > i; j--)
            sorted_vals[j] = sorted_vals[j-1];
        sorted_vals[i] = v;
    endtask

    task automatic sorted_remove(input logic signed [SMP_W-1:0] v, input int n);
        int i;
        i = 0;
        while (i < n && sorted_vals[i] != v)
            i++;
        if (i < n)
            for (int j = i; j < n - 1; j++)
                sorted_vals[j] = sorted_vals[j+1];
    endtask

    task automatic predict_median(input logic signed [SMP_W-1:0] smp, input logic restart);
        int w;
        logic signed [MED_W-1:0] lo;
        logic signed [MED_W-1:0] hi;
        w = window_len();
        if (restart)
        begin
            fill_n = 0;
            ring_ptr = 0;
        end
        if (fill_n > w)
            fill_n = 0;
        if (ring_ptr >= w)
            ring_ptr = 0;
        if (fill_n == w)
        begin
            sorted_remove(arrival_ring[ring_ptr], w);
            sorted_insert(smp, w - 1);
        end
        else
        begin
            sorted_insert(smp, fill_n);
            fill_n++;
        end
        arrival_ring[ring_ptr] = smp;
        ring_ptr++;
        if (ring_ptr >= w)
            ring_ptr = 0;
        if (fill_n == w)
        begin
            if (w % 2 == 1)
            begin
                lo = sorted_vals[w/2];
                hi = sorted_vals[w/2];
            end
            else
            begin
                lo = sorted_vals[w/2 - 1];
                hi = sorted_vals[w/2];
            end
            expected_medians.insert(expected_medians.size(), lo + hi);
        end
    endtask

    // handshake monitor: config, results, accepted samples
    always @(posedge clk)
    begin : monitor
        logic signed [MED_W-1:0] got;
        logic signed [MED_W-1:0] want;
        if (rst_n)
        begin
            if (cfg_we)
            begin
                window_code = cfg_wdata;
                fill_n = 0;
                ring_ptr = 0;
                n_configs++;
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[MED_W-1:0];
                if (expected_medians.size() == 0)
                    report_mismatch($sformatf("median %0d with none expected", got));
                else
                begin
                    want = expected_medians.pop_front();
                    n_medians++;
                    if (got !== want)
                        report_mismatch($sformatf("median_x2 got %0d want %0d (W code %0d)",
                                                  got, want, window_code));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_median($signed(s_axis_tdata), s_axis_tuser);
                n_samples++;
            end
        end
    end

    // receiver stall pattern
    always @(posedge clk)
    begin : sink_pattern
        int mode;
        int left;
        int phase;
        if (left <= 0)
        begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
        end
        left--;
        phase++;
        case (mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= (phase % 4 != 0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no handshake for %0d cycles", IDLE_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [SMP_W-1:0] smp, input logic restart);
        int gap;
        if (burst_left <= 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tuser  <= restart;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (expected_medians.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    task automatic set_window(input logic [swm_pkg::WS_W-1:0] code);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8) - 4);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return -16'sd1;
                    default: return 16'sd0;
                endcase
            end
            default: return 16'($urandom_range(0, 600) - 300);
        endcase
    endfunction

    task automatic test_extremes_default_window();
        send_sample(16'sd32767, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(16'sd0, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
    endtask

    task automatic test_window_codes();
        // zero acts as a window of one
        set_window(7'd0);
        send_sample(-16'sd32768, 1'b1);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd0, 1'b0);
        // even window: sum of the two middles
        set_window(7'd2);
        send_sample(16'sd32767, 1'b0);
        send_sample(16'sd32767, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        send_sample(-16'sd32768, 1'b0);
        // restart in the middle of a fill
        send_sample(16'sd5, 1'b1);
        send_sample(-16'sd7, 1'b1);
        send_sample(16'sd9, 1'b0);
    endtask

    task automatic test_random_windows();
        logic [swm_pkg::WS_W-1:0] codes [$];
        logic [swm_pkg::WS_W-1:0] code;
        int sent;
        int phase_items;
        int restart_odds;
        int p;
        codes = {7'd1, 7'd4, 7'd5, 7'd8, 7'd16, 7'd31, 7'd33, 7'd63, 7'd64,
                 7'd65, 7'd127, 7'd0, 7'd3};
        sent = 0;
        p = 0;
        while (sent < ITEM_GOAL)
        begin
            if (p < codes.size())
                code = codes[p];
            else if ($urandom_range(0, 5) == 0)
                code = 7'($urandom_range(0, 127));
            else
                code = 7'($urandom_range(1, 12));
            p++;
            set_window(code);
            restart_odds = ($urandom_range(0, 3) == 0) ? 8 : 60;
            phase_items = (code == 0 ? 1 : (code > MAX_W ? MAX_W : code))
                          + $urandom_range(20, 90);
            for (int i = 0; i < phase_items; i++)
            begin
                send_sample(pick_sample(), $urandom_range(0, restart_odds - 1) == 0);
                sent++;
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes_default_window();
        test_window_codes();
        test_random_windows();
        wait_idle();
        if (expected_medians.size() != 0)
            report_mismatch($sformatf("%0d medians never arrived", expected_medians.size()));
        $display("Run covered %0d samples and %0d checked medians over %0d window writes,",
                 n_samples, n_medians, n_configs);
        $display("sizes 1..64 plus codes 0 and above 64, with restarts and output stalls.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
